FILE: rtl/core/utf8cc_pkg.sv
// ----------------------------------------------------------------------------
// utf8cc_pkg: shared types and constants for the UTF-8 character classifier
// Lead byte prefixes, special character codes and the word/flag structs.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8cc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned PendW  = 2;
  localparam int unsigned PartW  = 24;

  // Lead byte prefixes
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;

  // Sequence lengths
  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  // Special multi-byte characters
  localparam logic [7:0]       Latin1Lead    = 8'hC3;
  localparam logic [WordW-1:0] CedillaLower  = 32'h0000_C3A7;
  localparam logic [WordW-1:0] CedillaUpper  = 32'h0000_C387;
  localparam logic [WordW-1:0] EnDash        = 32'h00E2_8093;
  localparam logic [WordW-1:0] Ellipsis      = 32'h00E2_80A6;
  localparam logic [WordW-1:0] LeftDblQuote  = 32'h00E2_809C;
  localparam logic [WordW-1:0] RightDblQuote = 32'h00E2_809D;

  // Completed character handed from the assembler to the classifier
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [LenW-1:0]  len;
  } char_t;

  // Class flags, packed as they go out on tuser (vowel lowest)
  typedef struct packed {
    logic digit;
    logic separator;
    logic consonant;
    logic vowel;
  } class_t;

endpackage

`default_nettype wire

FILE: rtl/core/utf8cc_assembler.sv
// ----------------------------------------------------------------------------
// utf8cc_assembler: byte to character assembly
// Tracks the open sequence and registers each completed character word.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cc_assembler (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [7:0]            in_byte_i,
  output logic                  char_valid_o,
  input  wire                   char_ready_i,
  output utf8cc_pkg::char_t     char_o
);

  logic [utf8cc_pkg::PendW-1:0] pend_q, pend_d;
  logic [utf8cc_pkg::PartW-1:0] part_q, part_d;
  logic [utf8cc_pkg::LenW-1:0]  seq_q, seq_d;
  logic                         cvalid_q, cvalid_d;
  utf8cc_pkg::char_t            char_q, char_d;
  logic                         accept;
  logic                         emit;
  logic [utf8cc_pkg::LenW-1:0]  lead_len;
  logic [utf8cc_pkg::PendW-1:0] pend_dec;

  assign in_ready_o = !cvalid_q || char_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pend_dec   = pend_q - 2'd1;

  always_comb begin
    if (in_byte_i[7:5] == utf8cc_pkg::Lead2Prefix) begin
      lead_len = utf8cc_pkg::Len2;
    end else if (in_byte_i[7:4] == utf8cc_pkg::Lead3Prefix) begin
      lead_len = utf8cc_pkg::Len3;
    end else if (in_byte_i[7:3] == utf8cc_pkg::Lead4Prefix) begin
      lead_len = utf8cc_pkg::Len4;
    end else begin
      lead_len = utf8cc_pkg::Len1;
    end
  end

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    seq_d  = seq_q;
    emit   = 1'b0;
    char_d = char_q;
    if (accept) begin
      if (pend_q == '0) begin
        if (lead_len == utf8cc_pkg::Len1) begin
          emit        = 1'b1;
          char_d.word = {24'd0, in_byte_i};
          char_d.len  = utf8cc_pkg::Len1;
        end else begin
          part_d = {16'd0, in_byte_i};
          seq_d  = lead_len;
          pend_d = lead_len[utf8cc_pkg::PendW-1:0] - 2'd1;
        end
      end else if (pend_dec == '0) begin
        emit        = 1'b1;
        char_d.word = {part_q, in_byte_i};
        char_d.len  = seq_q;
        pend_d      = '0;
        part_d      = '0;
        seq_d       = '0;
      end else begin
        pend_d = pend_dec;
        part_d = {part_q[15:0], in_byte_i};
      end
    end
  end

  always_comb begin
    if (accept) begin
      cvalid_d = emit;
    end else if (char_ready_i) begin
      cvalid_d = 1'b0;
    end else begin
      cvalid_d = cvalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      part_q   <= '0;
      seq_q    <= '0;
      cvalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      part_q   <= part_d;
      seq_q    <= seq_d;
      cvalid_q <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_valid_o = cvalid_q;
  assign char_o       = char_q;

endmodule

`default_nettype wire

FILE: rtl/core/utf8cc_classifier.sv
// ----------------------------------------------------------------------------
// utf8cc_classifier: character class decode
// Compares a packed character word against the vowel, consonant,
// separator and digit sets.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cc_classifier (
  input  wire  [31:0]           word_i,
  output utf8cc_pkg::class_t    class_o
);

  logic       ascii;
  logic [7:0] lo;
  logic       ascii_vowel;
  logic       accent_vowel;
  logic       vowel;
  logic       letter;
  logic       sep;
  logic [7:0] folded;

  assign ascii  = (word_i[31:8] == 24'd0);
  assign lo     = word_i[7:0];
  // upper and lower case accented vowels differ only in bit 5
  assign folded = lo & 8'hDF;

  always_comb begin
    ascii_vowel = ascii && (lo inside {8'h61, 8'h65, 8'h69, 8'h6F, 8'h75,
                                       8'h41, 8'h45, 8'h49, 8'h4F, 8'h55});
    accent_vowel = (word_i[31:16] == 16'd0) && (word_i[15:8] == utf8cc_pkg::Latin1Lead) &&
                   (lo[7:6] == 2'b10) &&
                   (folded inside {[8'h80:8'h83], [8'h88:8'h8A], 8'h8C, 8'h8D,
                                   [8'h92:8'h95], 8'h99, 8'h9A});
    letter = (ascii && ((lo inside {[8'h41:8'h5A]}) || (lo inside {[8'h61:8'h7A]}))) ||
             (word_i == utf8cc_pkg::CedillaLower) || (word_i == utf8cc_pkg::CedillaUpper);
    sep = (ascii && (lo inside {8'h5B, 8'h5D, 8'h28, 8'h29, 8'h2D, 8'h22, 8'h20,
                                8'h09, 8'h0A, 8'h0D, 8'h2E, 8'h3F, 8'h3B, 8'h3A,
                                8'h2C, 8'h21})) ||
          (word_i == utf8cc_pkg::EnDash) || (word_i == utf8cc_pkg::Ellipsis) ||
          (word_i == utf8cc_pkg::LeftDblQuote) || (word_i == utf8cc_pkg::RightDblQuote);
    vowel = ascii_vowel || accent_vowel;

    class_o.vowel     = vowel;
    class_o.consonant = letter && !vowel;
    class_o.separator = sep;
    class_o.digit     = ascii && (lo inside {[8'h30:8'h39]});
  end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_char_assemble_classify.sv
// ----------------------------------------------------------------------------
// utf8_char_assemble_classify: UTF-8 character assembler and classifier
// Groups a byte stream into UTF-8 characters and tags each with class flags.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one text byte per word. The lead byte of
//   a sequence sets its length (2, 3 or 4 bytes for 110x, 1110x, 11110x
//   prefixes, 1 otherwise); following bytes are packed as they come without
//   any continuation check.
//   Master channel m_axis_* carries one word per completed character: the
//   big-endian packed bytes and byte count in tdata, class flags in tuser.
//   Bytes that do not finish a character produce no output word.
// Timing:
//   One byte accepted per cycle while m_axis_tready stays high. A byte that
//   completes a character lands in the assembler register when it is accepted,
//   then moves on into the result register, from which m_axis takes it.
// Reset:
//   rst_ni clears any open sequence and empties both pipeline registers.
// Backpressure:
//   When m_axis_tready is low the result register holds; the assembler keeps
//   taking bytes until it holds one more finished character, then
//   s_axis_tready drops. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_char_assemble_classify (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave: [7:0] text_byte
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,
  // master
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // tdata: [31:0] packed_char, [34:32] char_bytes, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  // tuser: [0] vowel_flag, [1] consonant_flag, [2] separator_flag, [3] digit_flag
  output logic [3:0]  m_axis_tuser_o
);

  utf8cc_pkg::char_t  char_s;
  utf8cc_pkg::class_t class_s;
  logic               char_valid;
  logic               char_ready;

  // result register
  logic               out_valid_q, out_valid_d;
  utf8cc_pkg::char_t  out_char_q;
  utf8cc_pkg::class_t out_class_q;
  logic               load;

  utf8cc_assembler u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .char_valid_o (char_valid),
    .char_ready_i (char_ready),
    .char_o       (char_s)
  );

  utf8cc_classifier u_cls (
    .word_i  (char_s.word),
    .class_o (class_s)
  );

  // result register frees up when empty or being drained this cycle
  assign char_ready = !out_valid_q || m_axis_tready_i;
  assign load       = char_valid && char_ready;

  always_comb begin
    if (char_ready) begin
      out_valid_d = char_valid;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q  <= char_s;
      out_class_q <= class_s;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_char_q.len, out_char_q.word};
  assign m_axis_tuser_o  = out_class_q;

`ifndef SYNTHESIS
  // byte count is always 1 to 4
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[34:32] != 3'd0 && m_axis_tdata_o[34:32] <= 3'd4))
    else $error("char_bytes out of range");

  // classes are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tuser_o))
    else $error("more than one class flag set");

  // a one-byte character carries no upper bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[34:32] == 3'd1) |-> (m_axis_tdata_o[31:8] == 24'd0))
    else $error("single-byte character with upper bytes set");

  // a two-byte character starts with the two-byte lead prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[34:32] == 3'd2) |-> (m_axis_tdata_o[15:13] == 3'b110))
    else $error("two-byte character without two-byte lead");

  // a stalled result register keeps the assembler from overrunning it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/utf8_char_assemble_classify_tb.sv
// ----------------------------------------------------------------------------
// utf8_char_assemble_classify_tb: self-checking bench for the UTF-8 classifier
// Feeds text bytes on s_axis and predicts each completed character. Checks
// the packed word, byte count and class flags of every m_axis word in order.
// ----------------------------------------------------------------------------

module utf8_char_assemble_classify_tb;

  import utf8cc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 400;
  localparam int HoldAfter   = 150;  // input words taken before the long stall
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 8;    // margin for a result still in the assembler and result registers

  // One expected character as it should leave on m_axis
  typedef struct {
    logic [WordW-1:0] word;
    logic [LenW-1:0]  len;
    class_t           cls;
  } char_result_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              s_valid = 1'b0;
  logic [ByteW-1:0]  s_data  = '0;
  logic              m_ready = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [39:0]       m_axis_tdata_o;
  logic [3:0]        m_axis_tuser_o;

  logic [ByteW-1:0]  text_bytes[$];     // bytes still to be offered
  char_result_t      pending_chars[$];  // characters predicted, not yet seen

  // Predictor copy of the assembler state
  logic [PendW-1:0]  open_left = '0;    // bytes missing from the open sequence
  logic [PartW-1:0]  gathered  = '0;    // bytes of that sequence so far
  logic [LenW-1:0]   open_len  = '0;

  int  cycle_count    = 0;
  int  accepted_bytes = 0;
  int  mismatches     = 0;
  bit  byte_taken     = 1'b0;           // s_axis handshake at the last rising edge

  // Sender burst shaping
  int  burst_left = 0;
  int  gap_left   = 0;

  // Receiver stall pattern and the one long hold-off
  int  ready_mode = 0;
  int  mode_left  = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  bit  next_ready = 1'b0;

  always #1 clk_i = ~clk_i;

  utf8_char_assemble_classify DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),          // [7:0] text_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] packed_char, [34:32] char_bytes
    .m_axis_tuser_o  (m_axis_tuser_o)   // vowel, consonant, separator, digit
  );

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------

  // ASCII vowels, and the accented Latin-1 vowels sent as C3 xx. The upper
  // case forms sit 0x20 below the lower case ones, so fold them together.
  function automatic bit vowel_match(logic [WordW-1:0] w);
    logic [7:0] folded;
    folded = w[7:0] | 8'h20;
    if (w[31:16] == 16'h0 && w[15:8] == Latin1Lead && w[7:6] == 2'b10) begin
      case (folded)
        8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA8, 8'hA9, 8'hAA, 8'hAC, 8'hAD,
        8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB9, 8'hBA: return 1'b1;
        default: return 1'b0;
      endcase
    end
    case (w)
      32'h61, 32'h65, 32'h69, 32'h6F, 32'h75,
      32'h41, 32'h45, 32'h49, 32'h4F, 32'h55: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_letter(logic [WordW-1:0] w);
    return (w >= 32'h41 && w <= 32'h5A) || (w >= 32'h61 && w <= 32'h7A) ||
           w == CedillaLower || w == CedillaUpper;
  endfunction

  function automatic bit sep_match(logic [WordW-1:0] w);
    case (w)
      32'h5B, 32'h5D, 32'h28, 32'h29, 32'h2D, 32'h22, 32'h20, 32'h09,
      32'h0A, 32'h0D, 32'h2E, 32'h3F, 32'h3B, 32'h3A, 32'h2C, 32'h21,
      EnDash, Ellipsis, LeftDblQuote, RightDblQuote: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic char_result_t tag_char(logic [WordW-1:0] w, logic [LenW-1:0] len);
    char_result_t r;
    r.word          = w;
    r.len           = len;
    r.cls.vowel     = vowel_match(w);
    r.cls.consonant = is_letter(w) && !vowel_match(w);
    r.cls.separator = sep_match(w);
    r.cls.digit     = (w >= 32'h30 && w <= 32'h39);
    return r;
  endfunction

  // Sequence length announced by a lead byte
  function automatic logic [LenW-1:0] lead_length(logic [ByteW-1:0] b);
    if (b[7:5] == Lead2Prefix) return Len2;
    if (b[7:4] == Lead3Prefix) return Len3;
    if (b[7:3] == Lead4Prefix) return Len4;
    return Len1;
  endfunction

  // Advance the predicted assembler by one accepted byte. Continuation
  // bytes are packed as they come, whatever their value.
  task automatic assemble_byte(logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    if (open_left == '0) begin
      len = lead_length(b);
      if (len == Len1) begin
        pending_chars.push_back(tag_char({24'h0, b}, Len1));
      end else begin
        gathered  = {16'h0, b};
        open_len  = len;
        open_left = PendW'(len - 3'd1);
      end
    end else begin
      open_left = open_left - 2'd1;
      if (open_left == '0) begin
        pending_chars.push_back(tag_char({gathered, b}, open_len));
        gathered = '0;
        open_len = '0;
      end else begin
        gathered = {gathered[15:0], b};
      end
    end
  endtask

  // Compare one m_axis word against the oldest predicted character
  task automatic check_char();
    char_result_t exp_char;
    class_t       got_cls;
    got_cls = class_t'(m_axis_tuser_o);
    if (pending_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0d] unexpected word: char %h bytes %0d flags %b pad %h", cycle_count,
                 m_axis_tdata_o[31:0], m_axis_tdata_o[34:32], got_cls, m_axis_tdata_o[39:35]);
    end else begin
      exp_char = pending_chars.pop_front();
      if (m_axis_tdata_o[31:0] !== exp_char.word || m_axis_tdata_o[34:32] !== exp_char.len ||
          got_cls !== exp_char.cls || m_axis_tdata_o[39:35] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0d] mismatch: exp %h/%0d/%b got %h/%0d/%b pad %h",
                   cycle_count, exp_char.word, exp_char.len, exp_char.cls,
                   m_axis_tdata_o[31:0], m_axis_tdata_o[34:32], got_cls, m_axis_tdata_o[39:35]);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: well-formed characters with random content, plus raw noise
  // bytes that leave sequences broken or stray continuation bytes alone.
  // --------------------------------------------------------------------------
  task automatic add_random_text();
    int          pick;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      text_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 60) begin
      // mostly Latin-1 accents, sometimes any 2-byte lead
      lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hC0, 8'hDF)) : Latin1Lead;
      text_bytes.push_back(lead);
      text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 72) begin
      if ($urandom_range(0, 3) == 0) begin
        text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        // general punctuation block: dashes, ellipsis, quotes and neighbors
        text_bytes.push_back(8'hE2);
        text_bytes.push_back(8'h80);
        case ($urandom_range(0, 4))
          0:       text_bytes.push_back(EnDash[7:0]);
          1:       text_bytes.push_back(Ellipsis[7:0]);
          2:       text_bytes.push_back(LeftDblQuote[7:0]);
          3:       text_bytes.push_back(RightDblQuote[7:0]);
          default: text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        endcase
      end
    end else if (pick < 82) begin
      text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, some with no gaps.
  // A word stays on the bus until it is taken.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (text_bytes.size() > 0) begin
        s_valid <= 1'b1;
        s_data  <= text_bytes.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns; once, well into the run,
  // it holds off long enough for the block to back up into s_axis.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (!hold_done && accepted_bytes >= HoldAfter) begin
      hold_done  = 1'b1;
      hold_left  = HoldCycles - 1;
      next_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      case (ready_mode)
        0:       next_ready = 1'b1;                        // no stalls
        1:       next_ready = ($urandom_range(0, 3) != 0); // light stalls
        2:       next_ready = ($urandom_range(0, 3) == 0); // heavy stalls
        default: next_ready = !m_ready;                    // alternate
      endcase
    end
    m_ready <= next_ready;
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge. The prediction for
  // an accepted byte is made before any output of the same edge is checked.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    byte_taken = rst_ni && s_valid && s_axis_tready_o;
    if (byte_taken) begin
      accepted_bytes++;
      assemble_byte(s_data);
    end
    if (rst_ni && m_axis_tvalid_o && m_ready) check_char();
    if (cycle_count > CycleLimit) begin
      $display("utf8_char_assemble_classify verification failed");
      $finish;
    end
  end

  initial begin
    // Directed opening: zero byte, FF, letters, digits, whitespace, stray
    // continuation and invalid lead bytes, accented vowel, upper case cedilla,
    // en dash, curly quote, a 4-byte character, a 2-byte sequence whose
    // continuation is ASCII, and a symbol with no class.
    text_bytes = {8'h00, 8'hFF, 8'h61, 8'h5A, 8'h30, 8'h39, 8'h20, 8'h80, 8'hF8,
                  8'hC3, 8'hA1, 8'hC3, 8'h87, 8'hE2, 8'h80, 8'h93, 8'hE2, 8'h80, 8'h9D,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3, 8'h41, 8'h23};
    while (text_bytes.size() < RandomBytes + 26) add_random_text();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // All bytes taken and every predicted character seen
    while (text_bytes.size() != 0 || s_valid || pending_chars.size() != 0)
      @(posedge clk_i);
    // Catch any stray word the block might still send
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("utf8_char_assemble_classify verification clean");
    end else begin
      $display("utf8_char_assemble_classify verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/utf8cc_pkg.sv
rtl/core/utf8cc_assembler.sv
rtl/core/utf8cc_classifier.sv
rtl/core/utf8_char_assemble_classify.sv
bench/utf8_char_assemble_classify_tb.sv
